// ----- rtl/core/ccp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared codes, widths and defaults of the circle canvas painter.
// ----------------------------------------------------------------------------
package ccp_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 512;
   localparam int MAX_HEIGHT_DEFAULT = 512;

   localparam int COORD_W   = 20;
   localparam int OPERAND_W = 21;
   localparam int SQUARE_W  = 41;
   localparam int SIZE_W    = 10;
   localparam int CHAR_W    = 8;

   localparam logic [1:0] ACT_DRAW  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_CODE   = 2'd1;
   localparam logic [1:0] ST_BAD_RADIUS = 2'd2;
   localparam logic [1:0] ST_OUTSIDE    = 2'd3;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BG     = 2'd2;

   localparam logic [7:0] CODE_OUTLINE = 8'h63;
   localparam logic [7:0] CODE_FILLED  = 8'h43;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd1;
   localparam logic [CHAR_W-1:0] BG_RESET   = 8'd32;

endpackage

// ----- rtl/core/ccp_squarer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_squarer
// Shared squaring unit with a registered result, one operand per cycle.
// ----------------------------------------------------------------------------
module ccp_squarer (
   input  logic                               clock,
   input  logic signed [ccp_pkg::OPERAND_W-1:0] operand,
   output logic        [ccp_pkg::SQUARE_W-1:0]  square
);
   import ccp_pkg::*;

   logic signed [2*OPERAND_W-1:0] product;
   logic        [SQUARE_W-1:0]    square_ff;

   assign product = operand * operand;

   always_ff @(posedge clock) begin
      square_ff <= SQUARE_W'(product);
   end

   assign square = square_ff;

endmodule

// ----- rtl/core/ccp_canvas_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_canvas_ram
// Canvas cell store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ccp_canvas_ram #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [ccp_pkg::CHAR_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [ccp_pkg::CHAR_W-1:0]  rd_data
);
   import ccp_pkg::*;

   logic [CHAR_W-1:0] mem_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/circle_canvas_painter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_canvas_painter
// Character canvas with clear, cell read and outline or filled circle draw.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high while
// it is worked on. Every item gives one result: rsp_valid is high for one
// cycle with rsp_status and rsp_cell_char, and the receiver cannot stall it.
// Rejected draws, reads outside the canvas and unused actions are answered
// straight from idle, with busy staying low; a read inside the canvas takes
// its character from the registered RAM read port.
// A draw runs every cell through one shared squarer, one cell per cycle,
// with an extra step per row to square the row offset. A clear writes one
// cell per cycle through the single RAM write port. Configuration writes
// land at once; the user must make them only while busy is low, as the
// block itself does not enforce this. Reset returns the sequencer and the
// size and background registers to their defaults; the canvas holds no
// defined contents until a clear has run.
// ----------------------------------------------------------------------------
module circle_canvas_painter #(
   parameter int MAX_WIDTH  = ccp_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ccp_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [7:0]                         req_shape_code,
   input  logic signed [ccp_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [ccp_pkg::COORD_W-1:0] req_center_y,
   input  logic signed [ccp_pkg::COORD_W-1:0] req_radius,
   input  logic [ccp_pkg::CHAR_W-1:0]         req_brush_char,
   input  logic [8:0]                         req_cell_x,
   input  logic [8:0]                         req_cell_y,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [ccp_pkg::CHAR_W-1:0]         rsp_cell_char,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [ccp_pkg::SIZE_W-1:0]         csr_wdata
);
   import ccp_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_DR_R2, S_DR_INNER, S_DR_ROW, S_DR_CELL, S_DR_DRAIN, S_CLEAR, S_READ
   } state_type;

   typedef enum logic [2:0] {
      TAG_NONE, TAG_R2, TAG_INNER, TAG_DY, TAG_CELL
   } sq_tag_type;

   state_type           state_ff, state_in;
   sq_tag_type          sq_tag_ff, sq_tag_in;
   logic [SIZE_W-1:0]   width_raw_ff, width_raw_in;
   logic [SIZE_W-1:0]   height_raw_ff, height_raw_in;
   logic [CHAR_W-1:0]   bg_ff, bg_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [SIZE_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [AW-1:0]       row_base_ff, row_base_in;
   logic [AW-1:0]       stage_addr_ff, stage_addr_in;
   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, r_ff, r_in;
   logic [CHAR_W-1:0]   brush_ff, brush_in;
   logic                outline_ff, outline_in;
   logic                has_inner_ff, has_inner_in;
   logic [SQUARE_W-1:0] r2_ff, r2_in, inner2_ff, inner2_in, dy2_ff, dy2_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_from_ram_ff, rsp_from_ram_in;

   logic [SIZE_W-1:0]   w_clamp, h_clamp, w_last, h_last;
   logic [AW-1:0]       addr_cur;
   logic signed [OPERAND_W-1:0] dx, dy, r_ext, r_minus, sq_a;
   logic [SQUARE_W-1:0] sq_q;
   logic [SQUARE_W:0]   d2;
   logic                hit;
   logic                ram_we, ram_rd_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [CHAR_W-1:0]   ram_wr_data, ram_rd_data;

   always_comb begin
      if (width_raw_ff == '0) begin
         w_clamp = SIZE_W'(1);
      end else if (32'(width_raw_ff) > MAX_WIDTH) begin
         w_clamp = SIZE_W'(MAX_WIDTH);
      end else begin
         w_clamp = width_raw_ff;
      end
      if (height_raw_ff == '0) begin
         h_clamp = SIZE_W'(1);
      end else if (32'(height_raw_ff) > MAX_HEIGHT) begin
         h_clamp = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_clamp = height_raw_ff;
      end
   end

   assign w_last   = w_clamp - SIZE_W'(1);
   assign h_last   = h_clamp - SIZE_W'(1);
   assign addr_cur = row_base_ff + AW'(x_ff);
   assign dx       = {cx_ff[COORD_W-1], cx_ff} - {3'b000, x_ff, 8'h00};
   assign dy       = {cy_ff[COORD_W-1], cy_ff} - {3'b000, y_ff, 8'h00};
   assign r_ext    = {r_ff[COORD_W-1], r_ff};
   assign r_minus  = r_ext - OPERAND_W'(256);
   assign d2       = {1'b0, sq_q} + {1'b0, dy2_ff};

   always_comb begin
      hit = d2 <= {1'b0, r2_ff};
      if (outline_ff && has_inner_ff && (d2 <= {1'b0, inner2_ff})) begin
         hit = 1'b0;
      end
   end

   ccp_squarer u_squarer (
      .clock   (clock),
      .operand (sq_a),
      .square  (sq_q)
   );

   ccp_canvas_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      sq_tag_in       = TAG_NONE;
      width_raw_in    = width_raw_ff;
      height_raw_in   = height_raw_ff;
      bg_in           = bg_ff;
      rsp_valid_in    = 1'b0;
      x_in            = x_ff;
      y_in            = y_ff;
      row_base_in     = row_base_ff;
      stage_addr_in   = stage_addr_ff;
      rd_addr_in      = rd_addr_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      r_in            = r_ff;
      brush_in        = brush_ff;
      outline_in      = outline_ff;
      has_inner_in    = has_inner_ff;
      r2_in           = r2_ff;
      inner2_in       = inner2_ff;
      dy2_in          = dy2_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_from_ram_in = rsp_from_ram_ff;
      sq_a            = dx;
      ram_we          = 1'b0;
      ram_wr_addr     = stage_addr_ff;
      ram_wr_data     = brush_ff;
      ram_rd_en       = 1'b0;

      if (csr_we) begin
         case (csr_index)
            REG_WIDTH:  width_raw_in  = csr_wdata;
            REG_HEIGHT: height_raw_in = csr_wdata;
            REG_BG:     bg_in         = csr_wdata[CHAR_W-1:0];
            default:    ;
         endcase
      end

      // retire what the squarer finished last cycle
      case (sq_tag_ff)
         TAG_R2:    r2_in     = sq_q;
         TAG_INNER: inner2_in = sq_q;
         TAG_DY:    dy2_in    = sq_q;
         TAG_CELL:  ram_we    = hit;
         default:   ;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in            = '0;
               y_in            = '0;
               row_base_in     = '0;
               cx_in           = req_center_x;
               cy_in           = req_center_y;
               r_in            = req_radius;
               brush_in        = req_brush_char;
               outline_in      = req_shape_code == CODE_OUTLINE;
               has_inner_in    = !req_radius[COORD_W-1] && (req_radius[COORD_W-2:8] != '0);
               rsp_status_in   = ST_OK;
               rsp_from_ram_in = 1'b0;
               rd_addr_in      = AW'(32'(req_cell_y) * MAX_WIDTH + 32'(req_cell_x));
               case (req_action)
                  ACT_DRAW: begin
                     if (req_shape_code != CODE_OUTLINE && req_shape_code != CODE_FILLED) begin
                        rsp_status_in = ST_BAD_CODE;
                        rsp_valid_in  = 1'b1;
                     end else if (req_radius[COORD_W-1] || req_radius == '0) begin
                        rsp_status_in = ST_BAD_RADIUS;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_DR_R2;
                     end
                  end
                  ACT_READ: begin
                     if ({1'b0, req_cell_x} >= w_clamp || {1'b0, req_cell_y} >= h_clamp) begin
                        rsp_status_in = ST_OUTSIDE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  ACT_CLEAR: state_in = S_CLEAR;
                  default:   rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_DR_R2: begin
            sq_a      = r_ext;
            sq_tag_in = TAG_R2;
            state_in  = S_DR_INNER;
         end
         S_DR_INNER: begin
            sq_a      = r_minus;
            sq_tag_in = TAG_INNER;
            state_in  = S_DR_ROW;
         end
         S_DR_ROW: begin
            sq_a      = dy;
            sq_tag_in = TAG_DY;
            state_in  = S_DR_CELL;
         end
         S_DR_CELL: begin
            sq_a          = dx;
            sq_tag_in     = TAG_CELL;
            stage_addr_in = addr_cur;
            if (x_ff == w_last) begin
               x_in = '0;
               if (y_ff == h_last) begin
                  state_in = S_DR_DRAIN;
               end else begin
                  y_in        = y_ff + SIZE_W'(1);
                  row_base_in = row_base_ff + AW'(MAX_WIDTH);
                  state_in    = S_DR_ROW;
               end
            end else begin
               x_in = x_ff + SIZE_W'(1);
            end
         end
         S_DR_DRAIN: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = addr_cur;
            ram_wr_data = bg_ff;
            if (x_ff == w_last) begin
               x_in = '0;
               if (y_ff == h_last) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  y_in        = y_ff + SIZE_W'(1);
                  row_base_in = row_base_ff + AW'(MAX_WIDTH);
               end
            end else begin
               x_in = x_ff + SIZE_W'(1);
            end
         end
         S_READ: begin
            ram_rd_en       = 1'b1;
            rsp_from_ram_in = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sq_tag_ff     <= TAG_NONE;
         width_raw_ff  <= SIZE_RESET;
         height_raw_ff <= SIZE_RESET;
         bg_ff         <= BG_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sq_tag_ff     <= sq_tag_in;
         width_raw_ff  <= width_raw_in;
         height_raw_ff <= height_raw_in;
         bg_ff         <= bg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_ff            <= x_in;
      y_ff            <= y_in;
      row_base_ff     <= row_base_in;
      stage_addr_ff   <= stage_addr_in;
      rd_addr_ff      <= rd_addr_in;
      cx_ff           <= cx_in;
      cy_ff           <= cy_in;
      r_ff            <= r_in;
      brush_ff        <= brush_in;
      outline_ff      <= outline_in;
      has_inner_ff    <= has_inner_in;
      r2_ff           <= r2_in;
      inner2_ff       <= inner2_in;
      dy2_ff          <= dy2_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_from_ram_ff <= rsp_from_ram_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_cell_char = (rsp_valid_ff && rsp_from_ram_ff) ? ram_rd_data : '0;

endmodule

// ----- rtl/core/ccp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_checker
// Port-level checks on the circle canvas painter, bound to the top level.
// ----------------------------------------------------------------------------
module ccp_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_action,
   input logic [7:0] req_shape_code,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_cell_char
);
   import ccp_pkg::*;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("item finished without a result");

   a_bad_code: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_DRAW && req_shape_code != CODE_OUTLINE
       && req_shape_code != CODE_FILLED) |=> (rsp_valid && rsp_status == ST_BAD_CODE))
      else $error("bad shape code not rejected at once");

   a_unused_action: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action != ACT_DRAW && req_action != ACT_READ
       && req_action != ACT_CLEAR) |=> (rsp_valid && rsp_status == ST_OK
       && rsp_cell_char == '0))
      else $error("unused action not answered with ok");

   a_error_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_cell_char == '0)
      else $error("failed item returned a character");

endmodule

bind circle_canvas_painter ccp_checker u_ccp_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_action     (req_action),
   .req_shape_code (req_shape_code),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_cell_char  (rsp_cell_char)
);

// ----- tb/sv/canvas_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canvas_reply_checker
// Watches the item, reply and register ports of the circle canvas painter.
// It keeps its own copy of the canvas and the size and background registers.
// It works out the reply of every accepted item and compares each reply
// strobe, field by field, with the oldest reply still awaited.
// ----------------------------------------------------------------------------
module canvas_reply_checker #(
   parameter int MAX_W = ccp_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_H = ccp_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [1:0]                         req_action,
   input  logic [7:0]                         req_shape_code,
   input  logic signed [ccp_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [ccp_pkg::COORD_W-1:0] req_center_y,
   input  logic signed [ccp_pkg::COORD_W-1:0] req_radius,
   input  logic [ccp_pkg::CHAR_W-1:0]         req_brush_char,
   input  logic [8:0]                         req_cell_x,
   input  logic [8:0]                         req_cell_y,
   input  logic                               rsp_valid,
   input  logic [1:0]                         rsp_status,
   input  logic [ccp_pkg::CHAR_W-1:0]         rsp_cell_char,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [ccp_pkg::SIZE_W-1:0]         csr_wdata,
   output int                                 mismatches,
   output int                                 pending
);
   import ccp_pkg::*;

   typedef struct packed {
      logic [1:0]        status;
      logic [CHAR_W-1:0] cell_char;
   } reply_type;

   localparam longint ONE_Q8 = 256;

   bit [CHAR_W-1:0]   cells [MAX_W*MAX_H];
   logic [SIZE_W-1:0] width_reg  = SIZE_RESET;
   logic [SIZE_W-1:0] height_reg = SIZE_RESET;
   logic [CHAR_W-1:0] bg_reg     = BG_RESET;
   reply_type         awaited [$];
   int                fault_count = 0;

   function automatic int usable(logic [SIZE_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return int'(v);
   endfunction

   function automatic void paint_circle(bit outline, longint cx, longint cy, longint r,
                                        logic [CHAR_W-1:0] brush);
      int     w, h;
      longint r2, inner2, dx, dy, d2;
      bit     hit;
      w      = usable(width_reg, MAX_W);
      h      = usable(height_reg, MAX_H);
      r2     = r * r;
      inner2 = (r - ONE_Q8) * (r - ONE_Q8);
      for (int y = 0; y < h; y++) begin
         dy = cy - longint'(y) * ONE_Q8;
         for (int x = 0; x < w; x++) begin
            dx  = cx - longint'(x) * ONE_Q8;
            d2  = dx * dx + dy * dy;
            hit = (d2 <= r2) && !(outline && r >= ONE_Q8 && d2 <= inner2);
            if (hit) cells[y*MAX_W + x] = brush;
         end
      end
   endfunction

   function automatic reply_type answer_item();
      reply_type rep;
      int        w, h;
      longint    r;
      rep.status    = ST_OK;
      rep.cell_char = '0;
      w = usable(width_reg, MAX_W);
      h = usable(height_reg, MAX_H);
      r = longint'(req_radius);
      case (req_action)
         ACT_DRAW: begin
            if (req_shape_code != CODE_OUTLINE && req_shape_code != CODE_FILLED)
               rep.status = ST_BAD_CODE;
            else if (r <= 0)
               rep.status = ST_BAD_RADIUS;
            else
               paint_circle(req_shape_code == CODE_OUTLINE, longint'(req_center_x),
                            longint'(req_center_y), r, req_brush_char);
         end
         ACT_READ: begin
            if (req_cell_x >= w || req_cell_y >= h)
               rep.status = ST_OUTSIDE;
            else
               rep.cell_char = cells[int'(req_cell_y)*MAX_W + int'(req_cell_x)];
         end
         ACT_CLEAR: begin
            for (int y = 0; y < h; y++)
               for (int x = 0; x < w; x++)
                  cells[y*MAX_W + x] = bg_reg;
         end
         default: ;
      endcase
      return rep;
   endfunction

   always @(posedge clock) begin
      reply_type due;
      if (reset) begin
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
         bg_reg     = BG_RESET;
         awaited.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: reply with none awaited: status %0d cell_char 0x%02h",
                           $time, rsp_status, rsp_cell_char);
            end else begin
               due = awaited.pop_front();
               if (due.status !== rsp_status || due.cell_char !== rsp_cell_char) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%0t: reply mismatch: status exp %0d got %0d, %s%02h got 0x%02h",
                              $time, due.status, rsp_status, "cell_char exp 0x",
                              due.cell_char, rsp_cell_char);
               end
            end
         end
         if (start && !busy) awaited.push_back(answer_item());
         if (csr_we) begin
            case (csr_index)
               REG_WIDTH:  width_reg  = csr_wdata;
               REG_HEIGHT: height_reg = csr_wdata;
               REG_BG:     bg_reg     = csr_wdata[CHAR_W-1:0];
               default: ;
            endcase
         end
      end
      mismatches <= fault_count;
      pending    <= awaited.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the circle canvas painter.
// A directed opening covers reset values, both circle shapes, rejected
// codes and radii, the coordinate extremes and reads inside and outside the
// canvas. Random phases follow, each with its own canvas size (including the
// width and height extremes and a shrink without clear) and one of three sender pacings.
// ----------------------------------------------------------------------------
module testbench;
   import ccp_pkg::*;

   localparam int         MAX_W          = MAX_WIDTH_DEFAULT;
   localparam int         MAX_H          = MAX_HEIGHT_DEFAULT;
   localparam logic [1:0] ACT_UNUSED     = 2'd3;
   localparam int         NUM_PHASES     = 8;
   localparam int         PHASE_ITEMS    = 9;
   localparam int         WATCHDOG_LIMIT = 200000;
   localparam int         TAIL_CYCLES    = 16;

   typedef struct {
      logic [1:0]                action;
      logic [7:0]                code;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] rad;
      logic [CHAR_W-1:0]         brush;
      logic [8:0]                x;
      logic [8:0]                y;
   } canvas_item_type;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      start          = 1'b0;
   logic                      busy;
   logic [1:0]                req_action     = ACT_READ;
   logic [7:0]                req_shape_code = '0;
   logic signed [COORD_W-1:0] req_center_x   = '0;
   logic signed [COORD_W-1:0] req_center_y   = '0;
   logic signed [COORD_W-1:0] req_radius     = '0;
   logic [CHAR_W-1:0]         req_brush_char = '0;
   logic [8:0]                req_cell_x     = '0;
   logic [8:0]                req_cell_y     = '0;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [CHAR_W-1:0]         rsp_cell_char;
   logic                      csr_we         = 1'b0;
   logic [1:0]                csr_index      = REG_WIDTH;
   logic [SIZE_W-1:0]         csr_wdata      = '0;
   int                        mismatches;
   int                        pending;

   int use_w = 1;
   int use_h = 1;
   bit cleared [MAX_H][MAX_W];
   int n_draw, n_read, n_clear, n_unused, n_phases;

   circle_canvas_painter #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_shape_code(req_shape_code),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_radius(req_radius), .req_brush_char(req_brush_char),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_cell_char(rsp_cell_char),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   canvas_reply_checker #(.MAX_W(MAX_W), .MAX_H(MAX_H)) reply_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_shape_code(req_shape_code),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_radius(req_radius), .req_brush_char(req_brush_char),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_cell_char(rsp_cell_char),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic canvas_item_type noise_item(logic [1:0] act);
      canvas_item_type it;
      it.action = act;
      it.code   = 8'($urandom);
      it.cx     = COORD_W'($urandom);
      it.cy     = COORD_W'($urandom);
      it.rad    = COORD_W'($urandom);
      it.brush  = CHAR_W'($urandom);
      it.x      = 9'($urandom);
      it.y      = 9'($urandom);
      return it;
   endfunction

   function automatic canvas_item_type draw_item(logic [7:0] code, int cx, int cy, int r,
                                                 logic [CHAR_W-1:0] brush);
      canvas_item_type it;
      it       = noise_item(ACT_DRAW);
      it.code  = code;
      it.cx    = COORD_W'(cx);
      it.cy    = COORD_W'(cy);
      it.rad   = COORD_W'(r);
      it.brush = brush;
      return it;
   endfunction

   function automatic canvas_item_type read_item(int x, int y);
      canvas_item_type it;
      it   = noise_item(ACT_READ);
      it.x = 9'(x);
      it.y = 9'(y);
      return it;
   endfunction

   function automatic canvas_item_type random_item();
      canvas_item_type it;
      int              roll, span, x, y;
      roll = $urandom_range(99);
      if (roll < 34) begin
         span     = ((use_w > use_h) ? use_w : use_h) * 128 + 256;
         it       = noise_item(ACT_DRAW);
         it.code  = $urandom_range(1) ? CODE_OUTLINE : CODE_FILLED;
         it.cx    = COORD_W'($urandom_range(use_w * 256 + 511) - 256);
         it.cy    = COORD_W'($urandom_range(use_h * 256 + 511) - 256);
         it.rad   = COORD_W'(($urandom_range(7) == 0) ? $urandom_range(1, 255)
                                                      : $urandom_range(1, span));
         if ($urandom_range(2) == 0) begin
            it.cx[7:0] = 8'h00;
            it.cy[7:0] = 8'h00;
            if (it.rad >= 256) it.rad[7:0] = 8'h00;
         end
      end else if (roll < 40) begin
         it = noise_item(ACT_DRAW);
      end else if (roll < 44) begin
         it      = noise_item(ACT_DRAW);
         it.code = $urandom_range(1) ? CODE_OUTLINE : CODE_FILLED;
         it.rad  = COORD_W'(-$urandom_range(524288));
      end else if (roll < 80) begin
         x = $urandom_range(use_w - 1);
         y = $urandom_range(use_h - 1);
         if (!cleared[y][x]) begin
            x = 0;
            y = 0;
         end
         it = read_item(x, y);
      end else if (roll < 88) begin
         it = read_item($urandom_range(MAX_W - 1), $urandom_range(MAX_H - 1));
         if (it.x < use_w && it.y < use_h) begin
            if (use_w < MAX_W) it.x = 9'($urandom_range(MAX_W - 1, use_w));
            else it.y = 9'($urandom_range(MAX_H - 1, use_h));
         end
      end else if (roll < 95) begin
         it = noise_item(ACT_CLEAR);
      end else begin
         it = noise_item(ACT_UNUSED);
      end
      return it;
   endfunction

   task automatic send_item(input canvas_item_type it);
      req_action     <= it.action;
      req_shape_code <= it.code;
      req_center_x   <= it.cx;
      req_center_y   <= it.cy;
      req_radius     <= it.rad;
      req_brush_char <= it.brush;
      req_cell_x     <= it.x;
      req_cell_y     <= it.y;
      start          <= 1'b1;
      case (it.action)
         ACT_DRAW: n_draw++;
         ACT_READ: n_read++;
         ACT_CLEAR: begin
            n_clear++;
            for (int y = 0; y < use_h; y++)
               for (int x = 0; x < use_w; x++)
                  cleared[y][x] = 1'b1;
         end
         default: n_unused++;
      endcase
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
   endtask

   task automatic write_regs(input int w, input int h, input logic [CHAR_W-1:0] bg);
      logic [1:0] pad;
      pad       = 2'($urandom_range(3));
      csr_we    <= 1'b1;
      csr_index <= REG_WIDTH;
      csr_wdata <= SIZE_W'(w);
      @(posedge clock);
      csr_index <= REG_HEIGHT;
      csr_wdata <= SIZE_W'(h);
      @(posedge clock);
      csr_index <= REG_BG;
      csr_wdata <= {pad, bg};
      @(posedge clock);
      csr_we    <= 1'b0;
      use_w = (w == 0) ? 1 : (w > MAX_W) ? MAX_W : w;
      use_h = (h == 0) ? 1 : (h > MAX_H) ? MAX_H : h;
      n_phases++;
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int w, h, gap_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes and background
      send_item(noise_item(ACT_CLEAR));
      send_item(read_item(0, 0));
      send_item(read_item(1, 0));
      send_item(read_item(511, 511));
      hold_off();

      write_regs(20, 12, "."); 
      send_item(noise_item(ACT_CLEAR));
      send_item(draw_item(CODE_FILLED, 10 * 256, 6 * 256, 5 * 256, "#"));
      send_item(read_item(10, 6));
      send_item(read_item(15, 6));
      send_item(draw_item(CODE_OUTLINE, 5 * 256 + 128, 4 * 256 + 128, 3 * 256, "o"));
      send_item(read_item(5, 4));
      send_item(read_item(8, 4));
      send_item(draw_item(CODE_OUTLINE, 15 * 256, 2 * 256, 128, "x"));
      send_item(read_item(15, 2));
      send_item(draw_item(8'h00, 256, 256, 256, "?"));
      send_item(draw_item(8'hFF, 256, 256, 0, "?"));
      send_item(draw_item(CODE_FILLED, 256, 256, 0, "?"));
      send_item(draw_item(CODE_OUTLINE, 256, 256, -524288, "?"));
      send_item(draw_item(CODE_FILLED, -524288, -524288, 524287, 8'hFF));
      send_item(draw_item(CODE_OUTLINE, 524287, 524287, 524287, 8'h00));
      send_item(noise_item(ACT_UNUSED));
      send_item(read_item(0, 0));
      send_item(read_item(19, 11));
      send_item(read_item(20, 0));
      send_item(read_item(0, 12));

      for (int p = 0; p < NUM_PHASES; p++) begin
         hold_off();
         case (p)
            0: begin w = 1023; h = 2;    end
            1: begin w = 0;    h = 0;    end
            2: begin w = 3;    h = 1023; end
            3: begin w = 40;   h = 24;   end
            4: begin w = 17;   h = 9;    end
            7: begin w = 513;  h = 1;    end
            default: begin
               w = $urandom_range(1, 48);
               h = $urandom_range(1, 32);
            end
         endcase
         write_regs(w, h, (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom));
         // shrink without clear keeps the old contents
         if (p != 4) send_item(noise_item(ACT_CLEAR));
         gap_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 58 : 8;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < gap_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end else if ($urandom_range(99) < 4) begin
               hold_off();
            end
            send_item(random_item());
         end
      end

      hold_off();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d draws, %0d reads, %0d clears and %0d unused-action items",
               n_draw, n_read, n_clear, n_unused);
      $display("over %0d canvas settings, including full width, full height and a shrink.",
               n_phases + 1);
      if (mismatches == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
